### sv/drl_pkg.sv
// ----------------------------------------------------------------------------
// drl_pkg
// Shared types and codes for the deduplicating request list.
// ----------------------------------------------------------------------------
package drl_pkg;

   // Operation kinds carried on the request word's tuser
   localparam logic [1:0] KIND_INSERT   = 2'd0;
   localparam logic [1:0] KIND_MATCH_RM = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;
   localparam logic [1:0] KIND_POS_RM   = 2'd3;

   // Result status codes carried on the response word's tuser
   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_DUP  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;
   localparam logic [1:0] STAT_MISS = 2'd3;

   // Direction code that matches any stored direction on match-remove
   localparam logic [7:0] WILDCARD_DIR = 8'd105;

   // One stored request
   typedef struct packed {
      logic [7:0] direction;
      logic [7:0] floor;
   } entry_type;

   // One finished result handed from the sequencer to the output register
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_floor;
      logic [7:0] read_direction;
      logic [4:0] entry_count;
   } result_type;

endpackage

### sv/dedup_request_list_core.sv
// ----------------------------------------------------------------------------
// dedup_request_list_core
// Ordered list of up to DEPTH (floor, direction) requests with insert,
// match-remove, read and position-remove operations.
// ----------------------------------------------------------------------------
// One request word is taken at a time and req_tready stays low until its
// work is finished. The list lives in a single-port-read memory and one
// compare unit checks one entry per cycle. Insert and match-remove scan
// the stored entries in order. A remove then closes the gap by moving each
// later entry down one place, one entry per cycle. The result waits in an
// output register, so the next request word is accepted while the previous
// response is still pending; completing a second result waits for it.
// ----------------------------------------------------------------------------
module dedup_request_list_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // floor[7:0], direction[15:8], position[19:16]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // read_floor[7:0], read_direction[15:8],
                                    // entry_count[20:16]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import drl_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   entry_type       mem_wr_data;
   logic [AW-1:0]   mem_rd_addr;
   entry_type       mem_rd_data;
   logic            res_valid;
   logic            res_take;
   result_type      res;

   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_ff, rsp_in;

   drl_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   drl_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_kind      (req_tuser),
      .req_floor     (req_tdata[7:0]),
      .req_direction (req_tdata[15:8]),
      .req_position  (req_tdata[19:16]),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .res_valid     (res_valid),
      .res_take      (res_take),
      .res           (res)
   );

   // Load the output register when it is empty or draining
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Pack the response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'b000, rsp_ff.entry_count, rsp_ff.read_direction,
                        rsp_ff.read_floor};

endmodule

### sv/drl_store.sv
// ----------------------------------------------------------------------------
// drl_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drl_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  drl_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output drl_pkg::entry_type  rd_data
);
   import drl_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/drl_match.sv
// ----------------------------------------------------------------------------
// drl_match
// Compare unit: checks one stored entry against the request key.
// ----------------------------------------------------------------------------
module drl_match (
   input  drl_pkg::entry_type  entry,
   input  drl_pkg::entry_type  key,
   input  logic                wild_en,
   output logic                hit
);
   import drl_pkg::*;

   logic floor_eq;
   logic dir_eq;

   // Floor must be equal; direction is equal or, with wild_en set, the key is the wildcard
   assign floor_eq = (entry.floor == key.floor);
   assign dir_eq   = (entry.direction == key.direction) ||
                     (wild_en && (key.direction == WILDCARD_DIR));
   assign hit      = floor_eq && dir_eq;

endmodule

### sv/drl_ctrl.sv
// ----------------------------------------------------------------------------
// drl_ctrl
// Sequencer: scans, shifts and reads the entry memory one entry per cycle
// and builds one result per request word.
// ----------------------------------------------------------------------------
module drl_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   input  logic [7:0]           req_floor,
   input  logic [7:0]           req_direction,
   input  logic [3:0]           req_position,
   output logic                 mem_wr_en,
   output logic [AW-1:0]        mem_wr_addr,
   output drl_pkg::entry_type   mem_wr_data,
   output logic [AW-1:0]        mem_rd_addr,
   input  drl_pkg::entry_type   mem_rd_data,
   output logic                 res_valid,
   input  logic                 res_take,
   output drl_pkg::result_type  res
);
   import drl_pkg::*;

   localparam int PW = (CW > 4) ? CW : 4;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_READ  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [1:0]     kind_ff, kind_in;
   entry_type      key_ff, key_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [1:0]     status_ff, status_in;
   logic [7:0]     rf_ff, rf_in;
   logic [7:0]     rd_ff, rd_in;

   logic [CW:0]    kp1;
   logic [CW:0]    kp2;
   logic [CW:0]    cnt_x;
   logic           last;
   logic           pos_ok;
   logic [PW:0]    pos_p1;
   logic           hit;
   logic [CW+4:0]  cnt_wide;

   // Index arithmetic for scan and shift, and the position checks for read and remove
   assign kp1    = (CW+1)'(k_ff) + (CW+1)'(1);
   assign kp2    = (CW+1)'(k_ff) + (CW+1)'(2);
   assign cnt_x  = (CW+1)'(count_ff);
   assign last   = (kp1 >= cnt_x);
   assign pos_ok = (PW'(req_position) < PW'(count_ff));
   assign pos_p1 = (PW+1)'(req_position) + (PW+1)'(1);

   drl_match u_match (
      .entry   (mem_rd_data),
      .key     (key_ff),
      .wild_en (kind_ff == KIND_MATCH_RM),
      .hit     (hit)
   );

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      k_in        = k_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      rf_in       = rf_ff;
      rd_in       = rd_ff;
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[AW-1:0];
      mem_wr_data = key_ff;
      mem_rd_addr = kp1[AW-1:0];
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in          = req_kind;
               key_in.floor     = req_floor;
               key_in.direction = req_direction;
               k_in             = '0;
               rf_in            = '0;
               rd_in            = '0;
               status_in        = STAT_DONE;
               mem_rd_addr      = '0;
               unique case (req_kind)
                  KIND_INSERT: begin
                     if (count_ff == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = key_in;
                        count_in    = CW'(1);
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_MATCH_RM: begin
                     if (count_ff == '0) begin
                        status_in = STAT_MISS;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_READ: begin
                     if (pos_ok) begin
                        mem_rd_addr = AW'(req_position);
                        state_in    = S_READ;
                     end else begin
                        status_in = STAT_MISS;
                        state_in  = S_DONE;
                     end
                  end
                  KIND_POS_RM: begin
                     if (pos_ok) begin
                        k_in        = CW'(req_position);
                        mem_rd_addr = pos_p1[AW-1:0];
                        state_in    = S_SHIFT;
                     end else begin
                        status_in = STAT_MISS;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Compare the entry at k; the read for k+1 is already issued
         S_SCAN: begin
            priority if (hit) begin
               if (kind_ff == KIND_INSERT) begin
                  status_in = STAT_DUP;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (last) begin
               if (kind_ff == KIND_INSERT) begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
               end else begin
                  status_in = STAT_MISS;
               end
               state_in = S_DONE;
            end else begin
               k_in = kp1[CW-1:0];
            end
         end

         // Move entry k+1 down to k until the tail is reached
         S_SHIFT: begin
            mem_rd_addr = kp2[AW-1:0];
            if (!last) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = k_ff[AW-1:0];
               mem_wr_data = mem_rd_data;
               k_in        = kp1[CW-1:0];
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end

         // Capture the entry at the requested position
         S_READ: begin
            rf_in    = mem_rd_data.floor;
            rd_in    = mem_rd_data.direction;
            state_in = S_DONE;
         end

         // Hold the result until the output register takes it
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      rf_ff     <= rf_in;
      rd_ff     <= rd_in;
   end

   // Report the low bits of the count
   assign cnt_wide           = (CW+5)'(count_ff);
   assign res.status         = status_ff;
   assign res.read_floor     = rf_ff;
   assign res.read_direction = rd_ff;
   assign res.entry_count    = cnt_wide[4:0];

endmodule

### sv/drl_checker.sv
// ----------------------------------------------------------------------------
// drl_checker
// Port-level checks for the deduplicating request list, bound to the core.
// ----------------------------------------------------------------------------
module drl_checker #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser
);
   import drl_pkg::*;

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // No response is pending right after reset
   a_rsp_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // The block is busy in the cycle after it takes a request word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in work");

   // Read fields are zero unless the operation succeeded
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_DONE) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("read fields nonzero on a failed operation");

   // The reported count never exceeds the list depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[20:16]) <= DEPTH))
      else $error("entry count above list depth");

endmodule

bind dedup_request_list_core drl_checker #(
   .DEPTH (DEPTH)
) u_drl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
